// ===== hdl/ejd_pkg.sv =====
// ----------------------------------------------------------------------------
// ejd_pkg
// Shared types, constants and fixed tables of the encoder unwrap and joint
// decoupler: command codes between controller and datapath, slot ordering.
// ----------------------------------------------------------------------------
package ejd_pkg;

    localparam int JOINTS_N   = 9;
    localparam int RAW_W      = 12;
    localparam int TURN_W     = 16;
    localparam int ANG_W      = 32;
    localparam int RATIO_W    = 16;
    localparam int VAL_W      = 48;
    localparam int ACC_W      = 64;
    localparam int Z_W        = 30;
    localparam int P_W        = 62;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 64;

    // half a turn of the 4096-count encoder
    localparam logic signed [RAW_W:0] HALF_TURN = 13'sd2048;
    // pi scaled by 2^29
    localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULLEY_MAIN = 3'd0,
        REG_PULLEY_AUX  = 3'd1,
        REG_COUPLE_MAIN = 3'd2,
        REG_COUPLE_AUX  = 3'd3,
        REG_OFFS_LOW    = 3'd4,
        REG_OFFS_HIGH   = 3'd5,
        REG_HAND_TYPE   = 3'd6,
        REG_UNUSED      = 3'd7
    } reg_idx_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ZPOS,
        OP_PROD,
        OP_MOTOR,
        OP_MAC,
        OP_ROUND,
        OP_EMIT
    } op_t;

    // ratio selection for the coupling multiply
    typedef enum logic [1:0] {
        RS_PULLEY_MAIN,
        RS_PULLEY_AUX,
        RS_COUPLE_MAIN,
        RS_COUPLE_AUX
    } rsel_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;    // joint or output slot
        logic [IDX_W-1:0] opnd;   // operand entry for multiply-accumulate
        rsel_t            rsel;
        logic             first;  // first term of a sum
    } cmd_t;

    typedef struct packed {
        logic out_hold;           // result register full and not taken
    } stat_t;

    // joint shown in output slot k
    function automatic logic [IDX_W-1:0] slot_joint(input logic hand,
                                                    input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] r;
        begin
            r = '0;
            unique case (k)
                4'd0: r = 4'd6;
                4'd1: r = 4'd7;
                4'd2: r = 4'd8;
                4'd3: r = hand ? 4'd4 : 4'd0;
                4'd4: r = hand ? 4'd5 : 4'd1;
                4'd5: r = 4'd2;
                4'd6: r = 4'd3;
                4'd7: r = hand ? 4'd0 : 4'd4;
                4'd8: r = hand ? 4'd1 : 4'd5;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // output slot that carries joint j (selects its offset)
    function automatic logic [IDX_W-1:0] joint_slot(input logic hand,
                                                    input logic [IDX_W-1:0] j);
        logic [IDX_W-1:0] r;
        begin
            r = '0;
            unique case (j)
                4'd0: r = hand ? 4'd7 : 4'd3;
                4'd1: r = hand ? 4'd8 : 4'd4;
                4'd2: r = 4'd5;
                4'd3: r = 4'd6;
                4'd4: r = hand ? 4'd3 : 4'd7;
                4'd5: r = hand ? 4'd4 : 4'd8;
                4'd6: r = 4'd0;
                4'd7: r = 4'd1;
                4'd8: r = 4'd2;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // joint whose motor sense is reversed
    function automatic logic joint_neg(input logic hand, input logic [IDX_W-1:0] j);
        logic r;
        begin
            r = 1'b0;
            unique case (j)
                4'd1, 4'd3, 4'd5: r = 1'b1;
                4'd6, 4'd7, 4'd8: r = !hand;
                default: r = 1'b0;
            endcase
            return r;
        end
    endfunction

    // saturate to 32 bits signed
    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        begin
            if (v > 64'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -64'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[ANG_W-1:0];
            return r;
        end
    endfunction

endpackage

// ===== hdl/encoder_unwrap_joint_decoupler_top.sv =====
// ----------------------------------------------------------------------------
// encoder_unwrap_joint_decoupler_top
// Multi-turn encoder unwrap and joint decoupler for a nine-joint hand.
// ----------------------------------------------------------------------------
// One control step (nine raw readings) takes one input transfer and gives nine
// result transfers in the hand type's slot order, tlast on slot 8. The block
// handles one step at a time: the unwrap of each motor in three steps through
// the unwrap multiplier, then fifteen multiply-accumulate terms and nine
// rounding steps on the shared coupling multiplier, then the load of the
// output register, after which results follow one per cycle while the sink
// is ready. A new step is taken the cycle after the last result is loaded
// into the output register; sink stalls delay that.
module encoder_unwrap_joint_decoupler_top
    import ejd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // raw_pos_0..8 (12 each), count_turns, compute_velocity, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // joint_angle (32), joint_velocity (32)
    output logic [OUT_DATA_W-1:0] m_tdata,
    // slot (4)
    output logic [IDX_W-1:0]      m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ejd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ejd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_slot  (m_tuser),
        .out_last  (m_tlast)
    );

    // result framing
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == IDX_W'(JOINTS_N - 1))
        else $error("tlast on a slot other than the final one");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser < IDX_W'(JOINTS_N))
        else $error("slot index out of range");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second step accepted while busy");

endmodule

// ===== hdl/ejd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ejd_ctrl
// Sequencer: unwrap of each motor in three steps, the coupling chain as
// multiply-accumulate terms, then the nine results one per cycle unless held.
// ----------------------------------------------------------------------------
module ejd_ctrl
    import ejd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_MAC,
        ST_ROUND,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [1:0]       ph_reg, ph_next;
    logic [1:0]       t_reg, t_next;
    logic [1:0]       nterm;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOINTS_N - 1);

    assign in_ready = (state_reg == ST_IDLE);

    // index of the last product term of each joint in the chain
    always_comb
    begin
        unique case (j_reg)
            4'd1, 4'd3, 4'd5, 4'd7: nterm = 2'd1;
            4'd8:                   nterm = 2'd2;
            default:                nterm = 2'd0;
        endcase
    end

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        t_next     = t_reg;
        cmd        = '{op: OP_NONE, idx: j_reg, opnd: j_reg,
                       rsel: RS_PULLEY_MAIN, first: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_UNWRAP;
                    j_next     = '0;
                    ph_next    = '0;
                end
            end
            ST_UNWRAP:
            begin
                unique case (ph_reg)
                    2'd0:    cmd.op = OP_ZPOS;
                    2'd1:    cmd.op = OP_PROD;
                    default: cmd.op = OP_MOTOR;
                endcase
                if (ph_reg == 2'd2)
                begin
                    ph_next = '0;
                    if (j_reg == LAST_IDX)
                    begin
                        state_next = ST_MAC;
                        j_next     = '0;
                        t_next     = '0;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                    ph_next = ph_reg + 1'b1;
            end
            ST_MAC:
            begin
                cmd.op    = OP_MAC;
                cmd.first = (t_reg == 2'd0);
                unique case (t_reg)
                    2'd0:
                    begin
                        cmd.opnd = j_reg;
                        cmd.rsel = (j_reg == 4'd6) ? RS_PULLEY_AUX : RS_PULLEY_MAIN;
                    end
                    2'd1:
                    begin
                        cmd.opnd = (j_reg >= 4'd7) ? 4'd6 : j_reg - 1'b1;
                        cmd.rsel = (j_reg >= 4'd7) ? RS_COUPLE_AUX : RS_COUPLE_MAIN;
                    end
                    default:
                    begin
                        cmd.opnd = 4'd7;
                        cmd.rsel = RS_COUPLE_MAIN;
                    end
                endcase
                if (t_reg == nterm)
                    state_next = ST_ROUND;
                else
                    t_next = t_reg + 1'b1;
            end
            ST_ROUND:
            begin
                cmd.op = OP_ROUND;
                t_next = '0;
                if (j_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                    j_next     = '0;
                end
                else
                begin
                    state_next = ST_MAC;
                    j_next     = j_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_hold)
                begin
                    cmd.op = OP_EMIT;
                    if (j_reg == LAST_IDX)
                        state_next = ST_IDLE;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            ph_reg    <= '0;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            ph_reg    <= ph_next;
            t_reg     <= t_next;
        end
    end

    // sequencing checks
    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MAC |-> (t_reg <= nterm))
        else $error("chain term beyond joint's term count");
    a_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_LOAD |=> !in_ready)
        else $error("input taken again before step completed");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |-> !stat.out_hold)
        else $error("result overwritten before transfer");

endmodule

// ===== hdl/ejd_datapath.sv =====
// ----------------------------------------------------------------------------
// ejd_datapath
// Configuration registers, per-motor state, unwrap multiplier, shared
// coupling multiply-accumulate and the result register.
// ----------------------------------------------------------------------------
module ejd_datapath
    import ejd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [IDX_W-1:0]      out_slot,
    output logic                  out_last
);

    localparam int OFFS_W = RAW_W * JOINTS_N;

    // configuration
    logic signed [RATIO_W-1:0] pm_reg, pa_reg, cm_reg, ca_reg;
    logic [OFFS_W-1:0]         offs_reg;
    logic                      hand_reg;

    // per-motor state
    logic [RAW_W-1:0]          prev_raw_reg [JOINTS_N];
    logic signed [TURN_W-1:0]  turn_reg     [JOINTS_N];
    logic signed [ANG_W-1:0]   prev_ang_reg [JOINTS_N];

    // working storage of one step
    logic [RAW_W-1:0]          raw_reg [JOINTS_N];
    logic                      turns_reg, velo_reg;
    logic signed [VAL_W-1:0]   val_reg [JOINTS_N];
    logic signed [ANG_W-1:0]   ang_reg [JOINTS_N];
    logic signed [ANG_W-1:0]   vel_reg [JOINTS_N];
    logic signed [Z_W-1:0]     z_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [IDX_W-1:0]          out_slot_reg;

    // unwrap of the selected motor
    logic [RAW_W-1:0]          raw;
    logic signed [RAW_W:0]     dpos;
    logic signed [TURN_W-1:0]  turn_cur, turn_new;
    logic [RAW_W-1:0]          offs;
    logic [IDX_W-1:0]          oslot;
    logic signed [Z_W-1:0]     zsum, z_next;
    logic signed [P_W-1:0]     p_next;
    logic signed [P_W-1:0]     m_full;
    logic signed [RATIO_W-1:0] ratio;
    logic signed [ACC_W-1:0]   prod, q_full;
    logic signed [ANG_W-1:0]   ang, vel;
    logic signed [ANG_W:0]     dang;
    logic signed [ACC_W-1:0]   dang_x, vel_full;
    logic [IDX_W-1:0]          ej;

    always_comb
    begin
        raw      = raw_reg[cmd.idx];
        dpos     = $signed({1'b0, raw}) - $signed({1'b0, prev_raw_reg[cmd.idx]});
        turn_cur = turn_reg[cmd.idx];
        turn_new = turn_cur;
        if (turns_reg)
        begin
            if (dpos > HALF_TURN && turn_cur != 16'sh8000)
                turn_new = turn_cur - 1'b1;
            else if (dpos < -HALF_TURN && turn_cur != 16'sh7FFF)
                turn_new = turn_cur + 1'b1;
        end
        oslot  = joint_slot(hand_reg, cmd.idx);
        offs   = offs_reg[oslot*RAW_W +: RAW_W];
        zsum   = $signed({{(Z_W-RAW_W){1'b0}}, raw})
               + ($signed({{(Z_W-TURN_W){turn_new[TURN_W-1]}}, turn_new}) <<< RAW_W)
               - $signed({{(Z_W-RAW_W){1'b0}}, offs});
        z_next = joint_neg(hand_reg, cmd.idx) ? -zsum : zsum;
    end

    // scale to radians, rounded to nearest with ties away from zero
    assign p_next = P_W'(z_reg) * P_W'(PI_Q29);
    assign m_full = p_reg[P_W-1] ? (p_reg + P_W'(64'sd8388607)) >>> 24
                                 : (p_reg + P_W'(64'sd8388608)) >>> 24;

    // coupling chain multiply
    always_comb
    begin
        unique case (cmd.rsel)
            RS_PULLEY_MAIN: ratio = pm_reg;
            RS_PULLEY_AUX:  ratio = pa_reg;
            RS_COUPLE_MAIN: ratio = cm_reg;
            RS_COUPLE_AUX:  ratio = ca_reg;
            default:        ratio = pm_reg;
        endcase
        prod = ACC_W'(ratio) * ACC_W'(val_reg[cmd.opnd]);
    end

    // joint angle and velocity
    always_comb
    begin
        q_full   = acc_reg[ACC_W-1] ? (acc_reg + 64'sd2047) >>> 12
                                    : (acc_reg + 64'sd2048) >>> 12;
        ang      = sat32(q_full);
        dang     = $signed({ang[ANG_W-1], ang})
                 - $signed({prev_ang_reg[cmd.idx][ANG_W-1], prev_ang_reg[cmd.idx]});
        dang_x   = ACC_W'(dang);
        vel_full = (dang_x <<< 8) - (dang_x <<< 2) - (dang_x <<< 1);
        vel      = velo_reg ? sat32(vel_full) : '0;
        ej       = slot_joint(hand_reg, cmd.idx);
    end

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg   <= 16'sd4096;
            pa_reg   <= 16'sd4096;
            cm_reg   <= '0;
            ca_reg   <= '0;
            offs_reg <= '0;
            hand_reg <= 1'b0;
            for (int i = 0; i < JOINTS_N; i++)
            begin
                prev_raw_reg[i] <= '0;
                turn_reg[i]     <= '0;
                prev_ang_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_PULLEY_MAIN: pm_reg   <= cfg_data[RATIO_W-1:0];
                    REG_PULLEY_AUX:  pa_reg   <= cfg_data[RATIO_W-1:0];
                    REG_COUPLE_MAIN: cm_reg   <= cfg_data[RATIO_W-1:0];
                    REG_COUPLE_AUX:  ca_reg   <= cfg_data[RATIO_W-1:0];
                    REG_OFFS_LOW:    offs_reg[59:0]   <= cfg_data[59:0];
                    REG_OFFS_HIGH:   offs_reg[107:60] <= cfg_data[47:0];
                    REG_HAND_TYPE:   hand_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_ZPOS)
            begin
                prev_raw_reg[cmd.idx] <= raw;
                turn_reg[cmd.idx]     <= turn_new;
            end
            if (cmd.op == OP_ROUND)
                prev_ang_reg[cmd.idx] <= ang;
        end
    end

    // working registers of one step
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                for (int i = 0; i < JOINTS_N; i++)
                    raw_reg[i] <= in_data[i*RAW_W +: RAW_W];
                turns_reg <= in_data[OFFS_W];
                velo_reg  <= in_data[OFFS_W+1];
            end
            OP_ZPOS:  z_reg <= z_next;
            OP_PROD:  p_reg <= p_next;
            OP_MOTOR: val_reg[cmd.idx] <= m_full[VAL_W-1:0];
            OP_MAC:   acc_reg <= cmd.first ? prod : acc_reg + prod;
            OP_ROUND:
            begin
                val_reg[cmd.idx] <= q_full[VAL_W-1:0];
                ang_reg[cmd.idx] <= ang;
                vel_reg[cmd.idx] <= vel;
            end
            OP_EMIT:
            begin
                out_data_reg <= {vel_reg[ej], ang_reg[ej]};
                out_slot_reg <= cmd.idx;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.out_hold = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_slot      = out_slot_reg;
    assign out_last      = (out_slot_reg == IDX_W'(JOINTS_N - 1));

endmodule

// ===== dv/tb_encoder_unwrap_joint_decoupler_top.sv =====
// ----------------------------------------------------------------------------
// tb_encoder_unwrap_joint_decoupler_top
// Self-checking bench for the encoder unwrap and joint decoupler: steps of
// nine raw readings are driven on the input stream, a scoreboard unwraps,
// scales and decouples them in its own right and checks the nine results
// that each step gives, while the configuration is changed between phases.
// ----------------------------------------------------------------------------
module tb_encoder_unwrap_joint_decoupler_top
    import ejd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]        slot;
        logic signed [ANG_W-1:0] angle;
        logic signed [ANG_W-1:0] velocity;
        logic                    last;
    } joint_result_t;

    // --------------------------------------------------------------------
    // Scoreboard: own copy of state and registers, queue of pending results
    // --------------------------------------------------------------------
    class joint_scoreboard;
        logic [15:0]             r_pm, r_pa, r_cm, r_ca;
        logic [59:0]             r_offs_lo;
        logic [47:0]             r_offs_hi;
        logic                    r_hand;
        logic [RAW_W-1:0]        last_raw [JOINTS_N];
        logic signed [15:0]      turns [JOINTS_N];
        logic signed [ANG_W-1:0] last_ang [JOINTS_N];
        joint_result_t           pending [$];
        int                      errors;

        function new();
            r_pm = 16'd4096; r_pa = 16'd4096; r_cm = '0; r_ca = '0;
            r_offs_lo = '0; r_offs_hi = '0; r_hand = 1'b0; errors = 0;
            for (int i = 0; i < JOINTS_N; i++)
            begin
                last_raw[i] = '0; turns[i] = '0; last_ang[i] = '0;
            end
        endfunction

        function void write_reg(reg_idx_t idx, logic [63:0] v);
            case (idx)
                REG_PULLEY_MAIN: r_pm = v[15:0];
                REG_PULLEY_AUX:  r_pa = v[15:0];
                REG_COUPLE_MAIN: r_cm = v[15:0];
                REG_COUPLE_AUX:  r_ca = v[15:0];
                REG_OFFS_LOW:    r_offs_lo = v[59:0];
                REG_OFFS_HIGH:   r_offs_hi = v[47:0];
                REG_HAND_TYPE:   r_hand = v[0];
                default: ;
            endcase
        endfunction

        // rounded division, ties away from zero
        function longint rdiv(longint num, longint den);
            longint n, d, r;
            n = num < 0 ? -num : num;
            d = den < 0 ? -den : den;
            r = (n + d / 2) / d;
            return ((num < 0) != (den < 0)) ? -r : r;
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function int joint_of(int k);
            int rt [9] = '{6, 7, 8, 0, 1, 2, 3, 4, 5};
            int lf [9] = '{6, 7, 8, 4, 5, 2, 3, 0, 1};
            return r_hand ? lf[k] : rt[k];
        endfunction

        // note one accepted step and queue its nine results
        function void note_step(logic [IN_DATA_W-1:0] d);
            longint offs [JOINTS_N], mot [JOINTS_N], q [JOINTS_N];
            logic signed [31:0] ang [JOINTS_N], vel [JOINTS_N];
            longint pm, pa, cm, ca, z, delta;
            logic [RAW_W-1:0] raw;
            logic count, velo;
            int sgn;
            joint_result_t r;
            pm = longint'($signed(r_pm)); pa = longint'($signed(r_pa));
            cm = longint'($signed(r_cm)); ca = longint'($signed(r_ca));
            count = d[108];
            velo = d[109];
            for (int k = 0; k < JOINTS_N; k++)
                offs[joint_of(k)] = k < 5 ? longint'(r_offs_lo[12*k +: 12])
                                          : longint'(r_offs_hi[12*(k-5) +: 12]);
            for (int i = 0; i < JOINTS_N; i++)
            begin
                raw = d[12*i +: 12];
                delta = longint'(raw) - longint'(last_raw[i]);
                if (count)
                begin
                    if (delta > 2048)
                    begin
                        if (turns[i] != -16'sd32768) turns[i] = turns[i] - 1;
                    end
                    else if (delta < -2048)
                    begin
                        if (turns[i] != 16'sd32767) turns[i] = turns[i] + 1;
                    end
                end
                z = longint'(raw) + longint'(turns[i]) * 4096 - offs[i];
                sgn = (i == 1 || i == 3 || i == 5 || (i >= 6 && !r_hand)) ? -1 : 1;
                z = z * sgn;
                mot[i] = rdiv(z * 64'sd1686629713, 64'sd16777216);
                last_raw[i] = raw;
            end
            q[0] = rdiv(pm * mot[0], 4096);
            q[1] = rdiv(pm * mot[1] + cm * q[0], 4096);
            q[2] = rdiv(pm * mot[2], 4096);
            q[3] = rdiv(pm * mot[3] + cm * q[2], 4096);
            q[4] = rdiv(pm * mot[4], 4096);
            q[5] = rdiv(pm * mot[5] + cm * q[4], 4096);
            q[6] = rdiv(pa * mot[6], 4096);
            q[7] = rdiv(pm * mot[7] + ca * q[6], 4096);
            q[8] = rdiv(pm * mot[8] + ca * q[6] + cm * q[7], 4096);
            for (int i = 0; i < JOINTS_N; i++)
            begin
                ang[i] = clip32(q[i]);
                vel[i] = velo ? clip32((longint'(ang[i]) - longint'(last_ang[i])) * 250)
                              : '0;
                last_ang[i] = ang[i];
            end
            for (int k = 0; k < JOINTS_N; k++)
            begin
                r.slot = k[3:0];
                r.angle = ang[joint_of(k)];
                r.velocity = vel[joint_of(k)];
                r.last = (k == JOINTS_N - 1);
                pending.push_back(r);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic [IDX_W-1:0] slot, logic [63:0] data,
                                   logic last);
            joint_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer, slot %0d", slot);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (slot !== e.slot)
            begin
                $error("slot: expected %0d, got %0d", e.slot, slot);
                errors++;
            end
            if (data[31:0] !== e.angle)
            begin
                $error("joint_angle: expected %0d, got %0d", e.angle, $signed(data[31:0]));
                errors++;
            end
            if (data[63:32] !== e.velocity)
            begin
                $error("joint_velocity: expected %0d, got %0d", e.velocity,
                       $signed(data[63:32]));
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [IDX_W-1:0]      m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    encoder_unwrap_joint_decoupler_top DUT (.*);

    joint_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sink;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sink: random back-pressure, or a long hold when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result check at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata, m_tlast);

    task automatic write_cfg(reg_idx_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // one step transfer; valid stays high across back-to-back steps
    task automatic send_step(logic [107:0] raws, logic count, logic velo);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, velo, count, raws};
        do @(posedge clk); while (!s_tready);
        board.note_step({2'b00, velo, count, raws});
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic logic [107:0] rand_raws();
        logic [107:0] r;
        for (int i = 0; i < JOINTS_N; i++) r[12*i +: 12] = $urandom_range(4095);
        return r;
    endfunction

    // small moves from the previous reading, wrapping across zero
    function automatic logic [107:0] walk_raws(logic [107:0] p);
        logic [107:0] r;
        for (int i = 0; i < JOINTS_N; i++)
            r[12*i +: 12] = p[12*i +: 12] + 12'($signed($urandom_range(600)) - 300);
        return r;
    endfunction

    task automatic random_cfg();
        write_cfg(REG_PULLEY_MAIN, {$urandom, $urandom});
        write_cfg(REG_PULLEY_AUX, {$urandom, $urandom});
        write_cfg(REG_COUPLE_MAIN, $urandom_range(1) ? $urandom : $urandom_range(2048));
        write_cfg(REG_COUPLE_AUX, $urandom);
        write_cfg(REG_OFFS_LOW, {$urandom, $urandom});
        write_cfg(REG_OFFS_HIGH, {$urandom, $urandom});
        write_cfg(REG_HAND_TYPE, $urandom);
    endtask

    task automatic random_phase(int n);
        logic [107:0] p;
        p = rand_raws();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 7) p = walk_raws(p);
            else p = rand_raws();
            send_step(p, $urandom_range(9) != 0, $urandom_range(9) != 0);
        end
    endtask

    initial
    begin
        logic [107:0] p;
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PULLEY_MAIN;
        cfg_data = '0;
        send_idle_pct = 31;
        recv_idle_pct = 57;
        hold_sink = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset registers, extremes, half-turn jumps, wraps
        send_step('0, 1'b0, 1'b0);
        send_step({9{12'hFFF}}, 1'b1, 1'b1);
        send_step('0, 1'b1, 1'b1);
        send_step({9{12'd2048}}, 1'b1, 1'b1);
        send_step({9{12'd0}}, 1'b1, 1'b1);
        send_step({9{12'd2049}}, 1'b1, 1'b1);
        send_step({9{12'hAAA}}, 1'b1, 1'b0);
        send_step({9{12'h555}}, 1'b0, 1'b1);
        drain();
        // extreme ratios saturate angles and velocities
        write_cfg(REG_PULLEY_MAIN, 64'h7FFF);
        write_cfg(REG_PULLEY_AUX, 64'hFFFF_FFFF_8000);
        write_cfg(REG_COUPLE_MAIN, 64'h7FFF);
        write_cfg(REG_COUPLE_AUX, 64'h8000);
        write_cfg(REG_OFFS_LOW, '1);
        write_cfg(REG_OFFS_HIGH, '1);
        write_cfg(REG_HAND_TYPE, 64'd1);
        // wrap back and forth across zero, stepping turn counts down and back up
        for (int i = 0; i < 6; i++)
        begin
            send_step({9{12'hFFF}}, 1'b1, 1'b1);
            send_step({9{12'h000}}, 1'b1, 1'b1);
        end
        send_step({9{12'h800}}, 1'b1, 1'b1);
        drain();
        // hand type change alone keeps state
        write_cfg(REG_HAND_TYPE, 64'd0);
        send_step({9{12'h123}}, 1'b1, 1'b1);
        send_step({9{12'hEDC}}, 1'b1, 1'b1);
        drain();

        // random phases with idling patterns
        random_cfg();
        random_phase(60);
        // long sink hold while the source keeps offering
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            random_phase(5);
        join
        drain();
        send_idle_pct = 57;
        recv_idle_pct = 31;
        random_cfg();
        random_phase(60);
        drain();
        write_cfg(REG_PULLEY_MAIN, 64'd4096);
        write_cfg(REG_COUPLE_MAIN, 64'd0);
        write_cfg(REG_COUPLE_AUX, 64'd0);
        random_phase(30);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_cfg();
        random_phase(60);
        drain();
        random_cfg();
        p = rand_raws();
        for (int i = 0; i < 20; i++)
        begin
            p = walk_raws(p);
            send_step(p, 1'b1, 1'b1);
        end
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("[encoder_unwrap_joint_decoupler_top] OK");
        else
            $display("[encoder_unwrap_joint_decoupler_top] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #4ms;
        $display("[encoder_unwrap_joint_decoupler_top] ERROR");
        $finish;
    end
endmodule
